### hdl/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg
// types and constants shared by the rounded multiply-divide pipeline
// ----------------------------------------------------------------------------
package rmd_pkg;

    localparam int WIDTH = 32;
    localparam int DIV_STEPS = 2 * WIDTH;

    typedef struct packed {
        logic        mode;
        logic [31:0] number;
        logic [31:0] numerator;
        logic [31:0] denominator;
    } rmd_in_t;

    typedef struct packed {
        logic [31:0] quotient;
        logic        divide_by_zero;
        logic        overflow;
    } rmd_out_t;

    // side information that travels with each operation
    typedef struct packed {
        logic             neg;
        logic             dz;
        logic             zp;
        logic             mode;
        logic [WIDTH-1:0] md;
    } rmd_side_t;

    // state of one long-division step
    typedef struct packed {
        logic               valid;
        rmd_side_t          side;
        logic [WIDTH-1:0]   rem;
        logic [2*WIDTH-1:0] dvq;
    } rmd_div_t;

endpackage

### hdl/rounded_mul_div_32.sv
// ----------------------------------------------------------------------------
// rounded_mul_div_32
// scales a number by numerator/denominator with rounding to nearest
// ----------------------------------------------------------------------------
//  channel | direction | ports                      | payload
//  s_      | in        | s_valid s_ready s_data     | mode number numerator denominator
//  m_      | out       | m_valid m_ready m_data     | quotient divide_by_zero overflow
//
//  one transaction per cycle unless stalled; two prep stages, then one
//  registered division step per quotient bit, then one rounding stage
//  the whole pipeline advances together; it holds only while m_valid is high
//  and m_ready is low, so a stall loses and repeats nothing
//  aresetn (synchronous) clears every valid bit
// ----------------------------------------------------------------------------
module rounded_mul_div_32 (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rmd_pkg::rmd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rmd_pkg::rmd_out_t m_data
);
    localparam int N = rmd_pkg::DIV_STEPS;

    logic              en;
    rmd_pkg::rmd_div_t chain [0:N];

    // pipeline moves when the output slot is empty or being taken
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // magnitudes, sign and product
    rmd_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out_div  (chain[0])
    );

    // long division, one quotient bit per stage
    for (genvar i = 0; i < N; i++) begin : g_div
        rmd_div_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_div  (chain[i]),
            .out_div (chain[i+1])
        );
    end

    // rounding, sign, flags and output register
    rmd_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_div    (chain[N]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );
endmodule

### hdl/rmd_prep.sv
// ----------------------------------------------------------------------------
// rmd_prep
// operand magnitudes, sign of the result, then the full product
// ----------------------------------------------------------------------------
module rmd_prep (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  rmd_pkg::rmd_in_t in_data,
    output rmd_pkg::rmd_div_t out_div
);
    localparam int W = rmd_pkg::WIDTH;

    logic [W-1:0] a, b, d, ma, mb, md;
    logic         sgn;

    logic              v1_reg, v1_next;
    logic [W-1:0]      ma_reg, mb_reg;
    rmd_pkg::rmd_side_t side_reg, side_next;
    rmd_pkg::rmd_div_t out_reg, out_next;

    always_comb begin
        a   = in_data.number[W-1:0];
        b   = in_data.numerator[W-1:0];
        d   = in_data.denominator[W-1:0];
        sgn = in_data.mode;
        ma  = (sgn && a[W-1]) ? (~a + 1'b1) : a;
        mb  = (sgn && b[W-1]) ? (~b + 1'b1) : b;
        md  = (sgn && d[W-1]) ? (~d + 1'b1) : d;
        v1_next        = in_valid;
        side_next.mode = sgn;
        side_next.md   = md;
        side_next.dz   = (d == '0);
        side_next.zp   = (a == '0) || (b == '0);
        side_next.neg  = sgn && ((a[W-1] ^ b[W-1]) ^ d[W-1]);
    end

    always_comb begin
        out_next       = '0;
        out_next.valid = v1_reg;
        out_next.side  = side_reg;
        out_next.rem   = '0;
        out_next.dvq   = ma_reg * mb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            out_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg        <= v1_next;
            out_reg.valid <= out_next.valid;
        end
        if (en) begin
            ma_reg       <= ma;
            mb_reg       <= mb;
            side_reg     <= side_next;
            out_reg.side <= out_next.side;
            out_reg.rem  <= out_next.rem;
            out_reg.dvq  <= out_next.dvq;
        end
    end

    assign out_div = out_reg;
endmodule

### hdl/rmd_div_stage.sv
// ----------------------------------------------------------------------------
// rmd_div_stage
// one registered restoring-division step, one quotient bit
// ----------------------------------------------------------------------------
module rmd_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  rmd_pkg::rmd_div_t in_div,
    output rmd_pkg::rmd_div_t out_div
);
    localparam int W = rmd_pkg::WIDTH;

    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              ge;
    rmd_pkg::rmd_div_t st_reg, st_next;

    always_comb begin
        trial   = {in_div.rem, in_div.dvq[2*W-1]};
        diff    = trial - {1'b0, in_div.side.md};
        ge      = (trial >= {1'b0, in_div.side.md});
        st_next = in_div;
        st_next.rem = ge ? diff[W-1:0] : trial[W-1:0];
        st_next.dvq = {in_div.dvq[2*W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg.valid <= st_next.valid;
        end
        if (en) begin
            st_reg.side <= st_next.side;
            st_reg.rem  <= st_next.rem;
            st_reg.dvq  <= st_next.dvq;
        end
    end

    assign out_div = st_reg;
endmodule

### hdl/rmd_round.sv
// ----------------------------------------------------------------------------
// rmd_round
// round to nearest, apply sign, range check and output register
// ----------------------------------------------------------------------------
module rmd_round (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  rmd_pkg::rmd_div_t in_div,
    output logic              out_valid,
    output rmd_pkg::rmd_out_t out_data
);
    localparam int W = rmd_pkg::WIDTH;

    logic [2*W:0]      t;
    logic              up, neg;
    logic [W-1:0]      q;
    logic              valid_reg;
    rmd_pkg::rmd_out_t data_reg, data_next;

    always_comb begin
        up  = ({in_div.rem, 1'b0} >= {1'b0, in_div.side.md});
        t   = {1'b0, in_div.dvq} + {{(2*W){1'b0}}, up};
        neg = in_div.side.neg && !in_div.side.zp;
        q   = neg ? (~t[W-1:0] + 1'b1) : t[W-1:0];
        data_next = '0;
        if (in_div.side.dz) begin
            data_next.divide_by_zero = 1'b1;
        end else begin
            data_next.quotient = {{(32-W){1'b0}}, q};
            if (!in_div.side.mode) begin
                data_next.overflow = (t[2*W:W] != '0);
            end else if (neg) begin
                data_next.overflow = (t[2*W:W-1] != '0) && (t[W-2:0] != '0
                    || t[2*W:W] != '0);
            end else begin
                data_next.overflow = (t[2*W:W-1] != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_div.valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

### verif/rounded_mul_div_32_tb.sv
// ----------------------------------------------------------------------------
// rounded_mul_div_32_tb
// self-checking bench for the rounded multiply-divide pipeline
// ----------------------------------------------------------------------------
// a queue of operand transactions feeds a clocked driver; a clocked monitor
// compares each result with the scaled quotient computed on the bench side
// ----------------------------------------------------------------------------
module rounded_mul_div_32_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 2 * rmd_pkg::WIDTH + 3;
    localparam int N_RANDOM    = 1530;
    localparam int CYCLE_LIMIT = 400000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    rmd_pkg::rmd_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rmd_pkg::rmd_out_t m_data;

    rmd_pkg::rmd_in_t  pending_ops[$];
    rmd_pkg::rmd_out_t scaled_results[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       calm = 1'b0;         // stretch with no idling on either side
    int       hold_off = 0;        // long receiver back-pressure, in cycles

    always #2 aclk = ~aclk;

    rounded_mul_div_32 dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // bench-side scaling: rounded (number*numerator)/denominator
    function automatic rmd_pkg::rmd_out_t scale_op(rmd_pkg::rmd_in_t op);
        rmd_pkg::rmd_out_t res;
        logic [63:0]  ma, mb, md, prod, quo, rem;
        logic         neg;
        res = '0;
        if (op.denominator == 32'd0) begin
            res.divide_by_zero = 1'b1;
        end else if (!op.mode) begin
            prod = {32'd0, op.number} * {32'd0, op.numerator};
            md   = {32'd0, op.denominator};
            quo  = prod / md;
            rem  = prod % md;
            if ((rem << 1) >= md) quo = quo + 64'd1;
            res.overflow = (quo > 64'hFFFF_FFFF);
            res.quotient = quo[31:0];
        end else begin
            ma = op.number[31] ? (64'h1_0000_0000 - op.number) : {32'd0, op.number};
            mb = op.numerator[31] ? (64'h1_0000_0000 - op.numerator) : {32'd0, op.numerator};
            md = op.denominator[31] ? (64'h1_0000_0000 - op.denominator)
                                    : {32'd0, op.denominator};
            prod = ma * mb;
            quo  = prod / md;
            rem  = prod % md;
            if ((rem << 1) >= md) quo = quo + 64'd1;
            neg = (op.number[31] ^ op.numerator[31]) ^ op.denominator[31];
            if (prod == 64'd0) neg = 1'b0;
            if (neg) begin
                res.overflow = (quo > 64'h8000_0000);
                res.quotient = 32'(64'd0 - quo);
            end else begin
                res.overflow = (quo > 64'h7FFF_FFFF);
                res.quotient = quo[31:0];
            end
        end
        return res;
    endfunction

    // operand pattern biased towards edge values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(1, 16));
            5:       return 32'(-$signed($urandom_range(1, 16)));
            default: return $urandom();
        endcase
    endfunction

    task automatic add_op(logic m, logic [31:0] a, logic [31:0] b, logic [31:0] d);
        rmd_pkg::rmd_in_t op;
        op.mode = m;
        op.number = a;
        op.numerator = b;
        op.denominator = d;
        pending_ops.push_back(op);
    endtask

    // driver: offers the next pending transaction, idles at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
                s_data  <= pending_ops[0];
                s_valid <= 1'b1;
                scaled_results.push_back(scale_op(pending_ops[0]));
                void'(pending_ops.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: checks accepted results, drives m_ready with random stalls
    always @(posedge aclk) begin
        rmd_pkg::rmd_out_t exp_res;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (scaled_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                fail_count = fail_count + 1;
            end else begin
                exp_res = scaled_results.pop_front();
                if (m_data.quotient !== exp_res.quotient) begin
                    $display("%0t: quotient expected %h actual %h",
                             $time, exp_res.quotient, m_data.quotient);
                    fail_count = fail_count + 1;
                end
                if (m_data.divide_by_zero !== exp_res.divide_by_zero) begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, exp_res.divide_by_zero, m_data.divide_by_zero);
                    fail_count = fail_count + 1;
                end
                if (m_data.overflow !== exp_res.overflow) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, exp_res.overflow, m_data.overflow);
                    fail_count = fail_count + 1;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= aresetn && (calm || $urandom_range(0, 99) >= 23);
        end
        // one long hold-off early on so the pipeline fills and stalls s_ready
        if (cycle_count == 300) hold_off <= 200;
    end

    // calm stretch in the middle of the run
    always @(posedge aclk) begin
        calm <= (cycle_count >= 1500 && cycle_count < 2500);
    end

    // cycle limit watchdog
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** rounded_mul_div_32: FAILED **");
            $finish;
        end
    end

    initial begin
        // directed: extremes, both modes, zero divisor, ties, overflow
        add_op(1'b0, 32'd0, 32'd0, 32'd1);
        add_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);        // overflow, wraps
        add_op(1'b0, 32'd5, 32'd7, 32'd0);                        // zero divisor
        add_op(1'b1, 32'hFFFF_FFFF, 32'd3, 32'd0);
        add_op(1'b0, 32'd1, 32'd1, 32'd2);                        // unsigned tie up
        add_op(1'b0, 32'd3, 32'd1, 32'd2);
        add_op(1'b1, 32'hFFFF_FFFF, 32'd1, 32'd2);                // signed tie away
        add_op(1'b1, 32'd1, 32'd1, 32'hFFFF_FFFE);
        add_op(1'b1, 32'hFFFF_FFFD, 32'd1, 32'd2);
        add_op(1'b1, 32'h8000_0000, 32'h8000_0000, 32'd1);        // signed overflow
        add_op(1'b1, 32'h8000_0000, 32'd1, 32'd1);                // min fits
        add_op(1'b1, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);        // negated min
        add_op(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_op(1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);        // zero product
        add_op(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        add_op(1'b0, 32'h8000_0000, 32'd2, 32'd1);
        add_op(1'b0, 32'd10, 32'd10, 32'd3);
        add_op(1'b1, 32'hFFFF_FFF6, 32'd10, 32'd3);
        add_op(1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_FFFF);
        for (int i = 0; i < N_RANDOM; i++)
            add_op(1'($urandom_range(0, 1)), pick_operand(), pick_operand(),
                   pick_operand());

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_ops.size() == 0);
        @(posedge aclk iff (!s_valid || s_ready));
        wait (scaled_results.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0 && scaled_results.size() == 0) begin
            $display("** rounded_mul_div_32: PASSED **");
        end else begin
            $display("** rounded_mul_div_32: FAILED **");
        end
        $finish;
    end

endmodule

### rounded_mul_div_32.f
hdl/rmd_pkg.sv
hdl/rmd_prep.sv
hdl/rmd_div_stage.sv
hdl/rmd_round.sv
hdl/rounded_mul_div_32.sv
verif/rounded_mul_div_32_tb.sv
